FILE: design/free_list_slot_allocator_top_assert.svh
// assertion macros for the allocator rtl
`ifndef FREE_LIST_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define FREE_LIST_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication
`define FLSA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// next-cycle implication
`define FLSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

FILE: design/flsa_pkg.sv
package flsa_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 5;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } command_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NOTBUSY = 2'd3
  } status_t;

  typedef struct packed {
    command_t         command;
    logic [IDX_W-1:0] slot_index;
  } cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    status_t           status;
    logic [CNT_W-1:0]  busy_count;
  } rsp_t;

endpackage

FILE: design/flsa_ram.sv
module flsa_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/free_list_slot_allocator_top.sv
// free list slot allocator, lifo list of next links in a synchronous ram
// free: one per cycle unless rsp_stall, response registered at acceptance
// allocate: acceptance reads the head's link, then the pop state moves the
// head on and registers the response; no command is taken while in pop
// reset: synchronous, all slots free, head at the top slot, no ram clearing
// pass; per-slot link valid bits stand in for the reset links
`include "free_list_slot_allocator_top_assert.svh"

module free_list_slot_allocator_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  flsa_pkg::cmd_t cmd,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output flsa_pkg::rsp_t rsp
);

  localparam int SLOTS  = flsa_pkg::SLOTS;
  localparam int SLOT_W = flsa_pkg::SLOT_W;
  localparam int CNT_W  = flsa_pkg::CNT_W;
  localparam int IDX_W  = flsa_pkg::IDX_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_POP  = 2'b10
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] head;
  logic [CNT_W-1:0]  free_count;
  logic [SLOTS-1:0]  busy;
  logic [SLOTS-1:0]  link_valid;
  logic [SLOT_W-1:0] pop_slot;

  logic              cmd_accept;
  logic              rsp_free;
  logic              rsp_load;
  logic              is_alloc;
  logic              empty;
  logic              in_range;
  logic [SLOT_W-1:0] idx;
  logic              ram_we;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_rdata;
  logic [SLOT_W-1:0] link_next;
  flsa_pkg::status_t idle_status;

  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign cmd_stall  = (state != S_IDLE) || !rsp_free;
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign is_alloc   = cmd.command == flsa_pkg::CMD_ALLOC;
  assign empty      = free_count == '0;
  assign in_range   = cmd.slot_index < IDX_W'(SLOTS);
  assign idx        = cmd.slot_index[SLOT_W-1:0];
  assign ram_re     = cmd_accept && is_alloc && !empty;
  assign ram_we     = cmd_accept && !is_alloc && in_range && busy[idx];
  assign rsp_load   = (state == S_POP && rsp_free) || (cmd_accept && !ram_re);

  flsa_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (head),
    .re    (ram_re),
    .raddr (head),
    .rdata (ram_rdata)
  );

  // unwritten links fall back to the reset chain
  always_comb begin
    if (link_valid[pop_slot]) begin
      link_next = ram_rdata;
    end else if (pop_slot == '0) begin
      link_next = '0;
    end else begin
      link_next = pop_slot - SLOT_W'(1);
    end
  end

  always_comb begin
    if (is_alloc) begin
      idle_status = empty ? flsa_pkg::ST_FULL : flsa_pkg::ST_OK;
    end else if (!in_range) begin
      idle_status = flsa_pkg::ST_RANGE;
    end else if (!busy[idx]) begin
      idle_status = flsa_pkg::ST_NOTBUSY;
    end else begin
      idle_status = flsa_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= SLOT_W'(SLOTS - 1);
      free_count <= CNT_W'(SLOTS);
      busy       <= '0;
      link_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            if (ram_re) begin
              state <= S_POP;
            end
            if (ram_we) begin
              head            <= idx;
              busy[idx]       <= 1'b0;
              link_valid[idx] <= 1'b1;
              free_count      <= free_count + CNT_W'(1);
            end
          end
        end
        S_POP: begin
          if (rsp_free) begin
            head           <= link_next;
            free_count     <= free_count - CNT_W'(1);
            busy[pop_slot] <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ram_re) begin
      pop_slot <= head;
    end
    if (state == S_POP && rsp_free) begin
      rsp.granted_slot <= pop_slot;
      rsp.status       <= flsa_pkg::ST_OK;
      rsp.busy_count   <= CNT_W'(SLOTS) - free_count + CNT_W'(1);
    end else if (cmd_accept && !ram_re) begin
      rsp.granted_slot <= '0;
      rsp.status       <= idle_status;
      rsp.busy_count   <= CNT_W'(SLOTS) - free_count - (ram_we ? CNT_W'(1) : CNT_W'(0));
    end
  end

  `FLSA_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, free_count <= CNT_W'(SLOTS))
  `FLSA_ASSERT_IMPL(a_count_match, clk, rst, 1'b1,
                    ($countones(busy) + int'(free_count)) == SLOTS)
  `FLSA_ASSERT_IMPL(a_pop_free_slot, clk, rst, state == S_POP, !busy[pop_slot])
  `FLSA_ASSERT_NEXT(a_alloc_pops, clk, rst, ram_re, state == S_POP && pop_slot == $past(head))
  `FLSA_ASSERT_IMPL(a_one_ram_op, clk, rst, 1'b1, !(ram_re && ram_we))

endmodule

FILE: bench/free_list_slot_allocator_top_tb.sv
module free_list_slot_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = flsa_pkg::SLOTS;
  localparam int SLOT_W     = flsa_pkg::SLOT_W;
  localparam int IDX_W      = flsa_pkg::IDX_W;
  localparam int CNT_W      = flsa_pkg::CNT_W;
  localparam int IDLE_PCT   = 13;
  localparam int HOLD_LEN   = 300;
  localparam int STUCK_MAX  = 2000;
  localparam int PHASES     = 6;
  localparam int PHASE_LEN  = 192;

  class alloc_scoreboard;
    logic [IDX_W-1:0] link_of[SLOTS];
    bit               in_use[SLOTS];
    logic [IDX_W-1:0] top_slot;
    int unsigned      free_slots;
    flsa_pkg::rsp_t   expected_q[$];
    int               errors;

    function void reset_pool();
      for (int i = 0; i < SLOTS; i++) begin
        link_of[i] = (i == 0) ? '0 : IDX_W'(i - 1);
        in_use[i]  = 1'b0;
      end
      top_slot   = IDX_W'(SLOTS - 1);
      free_slots = SLOTS;
      expected_q.delete();
      errors     = 0;
    endfunction

    function void note_command(flsa_pkg::cmd_t c);
      flsa_pkg::rsp_t   r;
      logic [IDX_W-1:0] slot;
      r.granted_slot = '0;
      r.status       = flsa_pkg::ST_OK;
      if (c.command == flsa_pkg::CMD_ALLOC) begin
        if (free_slots == 0 || top_slot >= SLOTS) begin
          r.status = flsa_pkg::ST_FULL;
        end else begin
          slot           = top_slot;
          top_slot       = link_of[slot];
          free_slots     = free_slots - 1;
          in_use[slot]   = 1'b1;
          r.granted_slot = SLOT_W'(slot);
        end
      end else begin
        if (c.slot_index >= SLOTS) begin
          r.status = flsa_pkg::ST_RANGE;
        end else if (!in_use[c.slot_index]) begin
          r.status = flsa_pkg::ST_NOTBUSY;
        end else begin
          link_of[c.slot_index] = top_slot;
          top_slot              = c.slot_index;
          in_use[c.slot_index]  = 1'b0;
          free_slots            = free_slots + 1;
        end
      end
      r.busy_count = CNT_W'(SLOTS - free_slots);
      expected_q.push_back(r);
    endfunction

    function void check_response(flsa_pkg::rsp_t r);
      flsa_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response granted_slot %0d status %0d busy_count %0d",
                 $time, r.granted_slot, r.status, r.busy_count);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.granted_slot !== e.granted_slot) begin
        $display("%0t: granted_slot expected %0d actual %0d", $time, e.granted_slot,
                 r.granted_slot);
        errors++;
      end
      if (r.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, r.status);
        errors++;
      end
      if (r.busy_count !== e.busy_count) begin
        $display("%0t: busy_count expected %0d actual %0d", $time, e.busy_count,
                 r.busy_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int pick_busy();
      int busy_q[$];
      for (int i = 0; i < SLOTS; i++) begin
        if (in_use[i]) busy_q.push_back(i);
      end
      if (busy_q.size() == 0) return -1;
      return busy_q[$urandom_range(0, busy_q.size() - 1)];
    endfunction
  endclass

  logic           clk;
  logic           rst;
  logic           cmd_valid;
  logic           cmd_stall;
  flsa_pkg::cmd_t cmd;
  logic           rsp_valid;
  logic           rsp_stall;
  flsa_pkg::rsp_t rsp;

  alloc_scoreboard sb;
  bit send_idle_on;
  bit recv_idle_on;
  bit hold_req;
  int stuck_cycles;

  free_list_slot_allocator_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else begin
      if (cmd_valid && !cmd_stall) sb.note_command(cmd);
      if (rsp_valid && !rsp_stall) sb.check_response(rsp);
      if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_MAX) begin
        $display("%0t: watchdog expired", $time);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // response side
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        rsp_stall = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
      end else begin
        rsp_stall = recv_idle_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  function automatic flsa_pkg::cmd_t make_cmd(flsa_pkg::command_t op, int idx);
    flsa_pkg::cmd_t c;
    c.command    = op;
    c.slot_index = IDX_W'(idx);
    return c;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer, or later after an idle gap
  task automatic send_cmd(flsa_pkg::cmd_t c);
    cmd_valid = 1'b1;
    cmd       = c;
    do @(posedge clk); while (cmd_stall);
    @(negedge clk);
    if (send_idle_on && ($urandom_range(0, 99) < IDLE_PCT)) begin
      cmd_valid = 1'b0;
      cmd       = flsa_pkg::cmd_t'($urandom());
      @(negedge clk);
    end
  endtask

  task automatic wait_results();
    cmd_valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic flsa_pkg::cmd_t random_cmd(int alloc_pct);
    int roll;
    int slot;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) return make_cmd(flsa_pkg::CMD_ALLOC, $urandom_range(0, 31));
    roll = $urandom_range(0, 99);
    slot = sb.pick_busy();
    if (roll < 80 && slot >= 0) return make_cmd(flsa_pkg::CMD_FREE, slot);
    if (roll < 90) return make_cmd(flsa_pkg::CMD_FREE, $urandom_range(0, SLOTS - 1));
    return make_cmd(flsa_pkg::CMD_FREE, $urandom_range(SLOTS, 31));
  endfunction

  initial begin
    int alloc_mix[PHASES] = '{70, 30, 50, 85, 20, 50};
    sb = new();
    sb.reset_pool();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    hold_req     = 1'b0;
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: range edges, double free, fill to full, lifo reuse
    send_cmd(make_cmd(flsa_pkg::CMD_ALLOC, 31));
    send_cmd(make_cmd(flsa_pkg::CMD_FREE, 31));
    send_cmd(make_cmd(flsa_pkg::CMD_FREE, SLOTS));
    send_cmd(make_cmd(flsa_pkg::CMD_FREE, 0));
    send_cmd(make_cmd(flsa_pkg::CMD_FREE, SLOTS - 1));
    send_cmd(make_cmd(flsa_pkg::CMD_FREE, SLOTS - 1));
    for (int i = 0; i < SLOTS; i++) begin
      send_cmd(make_cmd(flsa_pkg::CMD_ALLOC, $urandom_range(0, 31)));
    end
    send_cmd(make_cmd(flsa_pkg::CMD_ALLOC, 0));
    send_cmd(make_cmd(flsa_pkg::CMD_FREE, 0));
    send_cmd(make_cmd(flsa_pkg::CMD_FREE, 7));
    send_cmd(make_cmd(flsa_pkg::CMD_ALLOC, 0));
    send_cmd(make_cmd(flsa_pkg::CMD_ALLOC, 31));
    send_cmd(make_cmd(flsa_pkg::CMD_ALLOC, 0));
    send_cmd(make_cmd(flsa_pkg::CMD_FREE, 31));
    wait_results();

    for (int ph = 0; ph < PHASES; ph++) begin
      send_idle_on = (ph != 1);
      recv_idle_on = (ph != 1);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_LEN; n++) send_cmd(random_cmd(alloc_mix[ph]));
      wait_results();
    end

    recv_idle_on = 1'b0;
    repeat (20) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d responses never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
